// File: rtl/tensor_detile_dequant_defines.svh
// ----------------------------------------------------------------------------
// tensor_detile_dequant_defines
// assertion macros shared by the checker of the detile and dequantize block
// ----------------------------------------------------------------------------
`ifndef TENSOR_DETILE_DEQUANT_DEFINES_SVH
`define TENSOR_DETILE_DEQUANT_DEFINES_SVH

// checked only outside reset
`define TDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/tdd_pkg.sv
// ----------------------------------------------------------------------------
// tdd_pkg
// types and constants of the tensor detile and dequantize block
// ----------------------------------------------------------------------------
`default_nettype none

package tdd_pkg;

  localparam int unsigned OFF_W         = 32;
  localparam int unsigned CHANNEL_BLOCK = 16;
  localparam int unsigned CB_SHIFT      = $clog2(CHANNEL_BLOCK);
  localparam int unsigned ROW_BLOCK     = 16;
  localparam int unsigned RB_SHIFT      = $clog2(ROW_BLOCK);
  localparam int unsigned STRIDE_ALIGN  = 63;
  localparam int unsigned DIM_W         = 16;
  localparam int unsigned BATCH_W       = 8;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SCALE_W       = 32;
  localparam int unsigned DEQ_W         = 41;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned BLKCNT_W      = DIM_W + 1 - CB_SHIFT;
  localparam int unsigned ROWCNT_W      = DIM_W + 1 - RB_SHIFT;
  localparam int unsigned PADC_W        = DIM_W + 1;
  localparam int unsigned SCALE_RESET   = 32'h0100_0000;

  typedef logic [OFF_W-1:0] off_t;

  typedef enum logic [1:0] {
    LAYOUT_NC1HWC2     = 2'd0,
    LAYOUT_HWC1C2      = 2'd1,
    LAYOUT_NC1HWC2_ALT = 2'd2,
    LAYOUT_HBWCH16     = 2'd3
  } layout_e;

  typedef enum logic {
    ORDER_NHWC = 1'b0,
    ORDER_NCHW = 1'b1
  } order_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_BATCH     = 3'd0,
    REG_DIM_HEIGHT    = 3'd1,
    REG_DIM_WIDTH     = 3'd2,
    REG_DIM_CHANNELS  = 3'd3,
    REG_NATIVE_LAYOUT = 3'd4,
    REG_DEST_ORDER    = 3'd5,
    REG_SCALE_Q24     = 3'd6,
    REG_ZERO_POINT    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]      dim_h;
    logic [DIM_W-1:0]      dim_w;
    logic [DIM_W-1:0]      dim_c;
    layout_e               layout;
    order_e                order;
    logic [SCALE_W-1:0]    scale;
    logic signed [BYTE_W-1:0] zp;
    logic [BLKCNT_W-1:0]   c1;
    logic [ROWCNT_W-1:0]   hblk;
    logic [PADC_W-1:0]     padc;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

// File: rtl/tdd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdd_cfg_regs
// configuration register file and the block counts derived from it
// ----------------------------------------------------------------------------
`default_nettype none

module tdd_cfg_regs import tdd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       cfg_ready_o,
  output cfg_t                       cfg_o
);

  logic [DIM_W-1:0]         dim_h_q, dim_h_d;
  logic [DIM_W-1:0]         dim_w_q, dim_w_d;
  logic [DIM_W-1:0]         dim_c_q, dim_c_d;
  layout_e                  layout_q, layout_d;
  order_e                   order_q, order_d;
  logic [SCALE_W-1:0]       scale_q, scale_d;
  logic signed [BYTE_W-1:0] zp_q, zp_d;
  logic [PADC_W-1:0]        c_sum;
  logic [PADC_W-1:0]        h_sum;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    dim_h_d  = dim_h_q;
    dim_w_d  = dim_w_q;
    dim_c_d  = dim_c_q;
    layout_d = layout_q;
    order_d  = order_q;
    scale_d  = scale_q;
    zp_d     = zp_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DIM_BATCH: begin
          // batch count is not kept, the write has no effect
        end
        REG_DIM_HEIGHT:    dim_h_d  = cfg_data_i[DIM_W-1:0];
        REG_DIM_WIDTH:     dim_w_d  = cfg_data_i[DIM_W-1:0];
        REG_DIM_CHANNELS:  dim_c_d  = cfg_data_i[DIM_W-1:0];
        REG_NATIVE_LAYOUT: layout_d = layout_e'(cfg_data_i[1:0]);
        REG_DEST_ORDER:    order_d  = order_e'(cfg_data_i[0]);
        REG_SCALE_Q24:     scale_d  = cfg_data_i[SCALE_W-1:0];
        REG_ZERO_POINT:    zp_d     = $signed(cfg_data_i[BYTE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_h_q  <= DIM_W'(1);
      dim_w_q  <= DIM_W'(1);
      dim_c_q  <= DIM_W'(1);
      layout_q <= LAYOUT_NC1HWC2;
      order_q  <= ORDER_NHWC;
      scale_q  <= SCALE_W'(SCALE_RESET);
      zp_q     <= '0;
    end else begin
      dim_h_q  <= dim_h_d;
      dim_w_q  <= dim_w_d;
      dim_c_q  <= dim_c_d;
      layout_q <= layout_d;
      order_q  <= order_d;
      scale_q  <= scale_d;
      zp_q     <= zp_d;
    end
  end

  // channel blocks and row blocks, rounded up
  assign c_sum = PADC_W'(dim_c_q) + PADC_W'(CHANNEL_BLOCK - 1);
  assign h_sum = PADC_W'(dim_h_q) + PADC_W'(ROW_BLOCK - 1);

  always_comb begin
    cfg_o.dim_h  = dim_h_q;
    cfg_o.dim_w  = dim_w_q;
    cfg_o.dim_c  = dim_c_q;
    cfg_o.layout = layout_q;
    cfg_o.order  = order_q;
    cfg_o.scale  = scale_q;
    cfg_o.zp     = zp_q;
    cfg_o.c1     = c_sum[PADC_W-1:CB_SHIFT];
    cfg_o.hblk   = h_sum[PADC_W-1:RB_SHIFT];
    cfg_o.padc   = {c_sum[PADC_W-1:CB_SHIFT], {CB_SHIFT{1'b0}}};
  end

endmodule

`default_nettype wire

// File: rtl/tdd_offset_pipe.sv
// ----------------------------------------------------------------------------
// tdd_offset_pipe
// three stage pipeline for the native and user offsets
// ----------------------------------------------------------------------------
`default_nettype none

module tdd_offset_pipe import tdd_pkg::*; (
  input  wire logic              clk_i,
  input  wire cfg_t              cfg_i,
  input  wire stage_en_t         en_i,
  input  wire logic [BATCH_W-1:0] coord_n_i,
  input  wire logic [DIM_W-1:0]  coord_h_i,
  input  wire logic [DIM_W-1:0]  coord_w_i,
  input  wire logic [DIM_W-1:0]  coord_c_i,
  output off_t                   source_offset_o,
  output off_t                   dest_offset_o
);

  localparam off_t ALIGN_MASK = off_t'(STRIDE_ALIGN);

  function automatic off_t mul_off(input off_t a, input off_t b);
    return a * b;
  endfunction

  logic is_hbw, is_pad, is_nchw;
  off_t n_x, h_x, w_x, c_x;
  off_t dh_x, dw_x, dc_x, padc_x;
  off_t ma, ma16, mb, mc, mc_op_a, mc_op_b;
  off_t rw, ba, tail2;
  off_t dst_op3;

  off_t a_q, a_d, b_q, b_d, c_q, c_d, row_q, row_d, nc_q, nc_d;
  logic [DIM_W-1:0] h1_q, w1_q, c1_q;
  off_t x_q, x_d, y_q, y_d, dst2_q, dst2_d;
  logic [DIM_W-1:0] w2_q, c2_q;
  off_t src3_q, src3_d, dst3_q, dst3_d;

  assign is_hbw  = (cfg_i.layout == LAYOUT_HBWCH16);
  assign is_pad  = (cfg_i.layout == LAYOUT_HWC1C2);
  assign is_nchw = (cfg_i.order == ORDER_NCHW);

  assign dh_x   = off_t'(cfg_i.dim_h);
  assign dw_x   = off_t'(cfg_i.dim_w);
  assign dc_x   = off_t'(cfg_i.dim_c);
  assign padc_x = off_t'(cfg_i.padc);

  // stage 1: first products of coordinates and dimensions
  assign n_x = off_t'(coord_n_i);
  assign h_x = off_t'(coord_h_i);
  assign w_x = off_t'(coord_w_i);
  assign c_x = off_t'(coord_c_i);

  assign ma   = is_hbw ? mul_off(dw_x, dc_x) : mul_off(dh_x, dw_x);
  assign ma16 = ma << CB_SHIFT;
  assign a_d  = is_hbw ? ((off_t'(ma << RB_SHIFT) + ALIGN_MASK) & ~ALIGN_MASK) : ma16;

  assign mb  = mul_off(n_x, is_hbw ? off_t'(cfg_i.hblk) : off_t'(cfg_i.c1));
  assign b_d = mb + (is_hbw ? (h_x >> RB_SHIFT) : (c_x >> CB_SHIFT));

  assign mc_op_a = (is_hbw || is_pad) ? w_x : h_x;
  assign mc_op_b = is_hbw ? dc_x : (is_pad ? padc_x : dw_x);
  assign mc      = mul_off(mc_op_a, mc_op_b);
  assign c_d     = is_pad ? mc : (is_hbw ? (mc << RB_SHIFT) : (mc << CB_SHIFT));

  assign row_d = mul_off(n_x, dh_x) + h_x;
  assign nc_d  = mul_off(n_x, dc_x) + c_x;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      row_q <= row_d;
      nc_q  <= nc_d;
      h1_q  <= coord_h_i;
      w1_q  <= coord_w_i;
      c1_q  <= coord_c_i;
    end
  end

  // stage 2: block base times plane or stride, row times width
  assign rw    = mul_off(row_q, dw_x);
  assign ba    = mul_off(b_q, a_q);
  assign tail2 = is_hbw
               ? ((off_t'(c1_q) << RB_SHIFT) + off_t'(h1_q[RB_SHIFT-1:0]))
               : ((off_t'(w1_q) << CB_SHIFT) + off_t'(c1_q[CB_SHIFT-1:0]));
  assign x_d    = is_pad ? rw : (ba + c_q + tail2);
  assign y_d    = c_q + off_t'(c1_q);
  assign dst2_d = is_nchw ? (mul_off(nc_q, dh_x) + off_t'(h1_q)) : (rw + off_t'(w1_q));

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      x_q    <= x_d;
      y_q    <= y_d;
      dst2_q <= dst2_d;
      w2_q   <= w1_q;
      c2_q   <= c1_q;
    end
  end

  // stage 3: padded channel product and last user dimension
  assign src3_d  = is_pad ? (mul_off(x_q, padc_x) + y_q) : x_q;
  assign dst_op3 = is_nchw ? dw_x : dc_x;
  assign dst3_d  = mul_off(dst2_q, dst_op3) + (is_nchw ? off_t'(w2_q) : off_t'(c2_q));

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      src3_q <= src3_d;
      dst3_q <= dst3_d;
    end
  end

  assign source_offset_o = src3_q;
  assign dest_offset_o   = dst3_q;

endmodule

`default_nettype wire

// File: rtl/tdd_dequant_pipe.sv
// ----------------------------------------------------------------------------
// tdd_dequant_pipe
// zero point removal and scale multiply, aligned to the offset pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module tdd_dequant_pipe import tdd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire cfg_t                     cfg_i,
  input  wire stage_en_t                en_i,
  input  wire logic signed [BYTE_W-1:0] raw_value_i,
  output logic signed [DEQ_W-1:0]       dequantized_value_o,
  output logic [BYTE_W-1:0]             byte_value_o
);

  logic signed [BYTE_W:0]       diff_q, diff_d;
  logic signed [SCALE_W:0]      scale_s;
  logic signed [DEQ_W:0]        prod_w;
  logic signed [DEQ_W-1:0]      prod_q, prod_d, deq3_q;
  logic [BYTE_W-1:0]            byte1_q, byte2_q, byte3_q;

  assign diff_d = (BYTE_W+1)'(raw_value_i) - (BYTE_W+1)'(cfg_i.zp);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      diff_q  <= diff_d;
      byte1_q <= raw_value_i;
    end
  end

  assign scale_s = $signed({1'b0, cfg_i.scale});
  assign prod_w  = diff_q * scale_s;
  assign prod_d  = prod_w[DEQ_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q  <= prod_d;
      byte2_q <= byte1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      deq3_q  <= prod_q;
      byte3_q <= byte2_q;
    end
  end

  assign dequantized_value_o = deq3_q;
  assign byte_value_o        = byte3_q;

endmodule

`default_nettype wire

// File: rtl/tensor_detile_dequant.sv
// ----------------------------------------------------------------------------
// tensor_detile_dequant
// native tiled offset, user offset and dequantized value of one int8 element
// ----------------------------------------------------------------------------
// channel    direction  handshake                  payload
// command    in         start / busy               coord_n/h/w/c_i, raw_value_i
// result     out        result_valid_o strobe      source_offset_o, dest_offset_o,
//                                                  dequantized_value_o, byte_value_o
// config     in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one word accepted per cycle, result registered through stages s1, s2 and s3
// the pipeline depth is set by the three chained multiplies of the user offset
// busy stays low and the result strobe lasts one cycle, no back pressure
// reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_detile_dequant import tdd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [BATCH_W-1:0]       coord_n_i,
  input  wire logic [DIM_W-1:0]         coord_h_i,
  input  wire logic [DIM_W-1:0]         coord_w_i,
  input  wire logic [DIM_W-1:0]         coord_c_i,
  input  wire logic signed [BYTE_W-1:0] raw_value_i,
  output logic                          result_valid_o,
  output logic [OFF_W-1:0]              source_offset_o,
  output logic [OFF_W-1:0]              dest_offset_o,
  output logic signed [DEQ_W-1:0]       dequantized_value_o,
  output logic [BYTE_W-1:0]             byte_value_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  cfg_t       cfg;
  stage_en_t  en;
  logic       accept;
  logic [2:0] vld_q, vld_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_d  = {vld_q[1:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en.s1 = accept;
  assign en.s2 = vld_q[0];
  assign en.s3 = vld_q[1];

  assign result_valid_o = vld_q[2];

  tdd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  tdd_offset_pipe u_offset (
    .clk_i           (clk_i),
    .cfg_i           (cfg),
    .en_i            (en),
    .coord_n_i       (coord_n_i),
    .coord_h_i       (coord_h_i),
    .coord_w_i       (coord_w_i),
    .coord_c_i       (coord_c_i),
    .source_offset_o (source_offset_o),
    .dest_offset_o   (dest_offset_o)
  );

  tdd_dequant_pipe u_dequant (
    .clk_i               (clk_i),
    .cfg_i               (cfg),
    .en_i                (en),
    .raw_value_i         (raw_value_i),
    .dequantized_value_o (dequantized_value_o),
    .byte_value_o        (byte_value_o)
  );

endmodule

`default_nettype wire

// File: rtl/tdd_checker.sv
// ----------------------------------------------------------------------------
// tdd_checker
// port level checks of the detile and dequantize block
// ----------------------------------------------------------------------------
`default_nettype none

`include "tensor_detile_dequant_defines.svh"

module tdd_checker import tdd_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic signed [BYTE_W-1:0] raw_value_i,
  input wire logic                     result_valid_o,
  input wire logic [BYTE_W-1:0]        byte_value_o
);

  `TDD_ASSERT(a_word_out, (start && !busy) |-> ##3 result_valid_o, "accepted word gave no result")
  `TDD_ASSERT(a_no_orphan, result_valid_o |-> $past(start && !busy, 3), "result without word")
  `TDD_ASSERT(a_byte_kept, result_valid_o |-> (byte_value_o == $past(raw_value_i, 3)), "byte lost")
  `TDD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !result_valid_o, "result strobe during reset")

endmodule

bind tensor_detile_dequant tdd_checker u_tdd_checker (.*);

`default_nettype wire
